>>> sv/webster_green_split_unit_defines.svh
// assertion macros shared by the checker of the green split unit
// depends on nothing; included by the checker file only
`ifndef WEBSTER_GREEN_SPLIT_UNIT_DEFINES_SVH
`define WEBSTER_GREEN_SPLIT_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define WGS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("webster green split check failed");

// next-cycle implication, disabled during reset
`define WGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("webster green split check failed");

`endif

>>> sv/wgs_pkg.sv
// constants, status codes and types of the webster green split unit
// depends on nothing; imported by every module of the block
`default_nettype none
package wgs_pkg;
    localparam int NUM_LINKS   = 24;
    localparam int NUM_PHASES  = 4;
    localparam int LINK_W      = 5;
    localparam int DEMAND_W    = 16;
    localparam int MASK_W      = 24;
    localparam int TIME_W      = 16;
    localparam int RATIO_W     = 18;
    localparam int TOTAL_W     = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int DIV_NUM_W   = 36;
    localparam int DIV_DEN_W   = 18;

    localparam logic [16:0] RATIO_MAX      = 17'd131071;
    localparam logic [17:0] RATIO_NONE     = 18'h30000;   // -1.0 in q2.16
    // round(d * 65536 / 2400) == floor((2048 * d + 37) / 75)
    localparam logic [15:0] RATIO_SAT_DEM  = 16'd4800;    // first demand that saturates
    localparam logic [23:0] RATIO_BIAS     = 24'd37;
    localparam logic [24:0] RECIP_75       = 25'd28633116; // ceil(2^31 / 75)
    localparam logic [18:0] RECIP_5        = 19'd419431;   // ceil(2^21 / 5)
    localparam logic [8:0]  STARTUP_LOSS   = 9'd256;
    localparam logic [11:0] FIXED_OVH2     = 12'd2560;    // twice the 5 s overhead
    localparam logic [14:0] CYCLE_MAX      = 15'd30720;
    localparam logic [16:0] Q_ONE          = 17'd65536;

    localparam logic [1:0] ST_COMPUTED  = 2'd0;
    localparam logic [1:0] ST_ZERO      = 2'd1;
    localparam logic [1:0] ST_OVERLOAD  = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    localparam logic [2:0] CFG_MASK_A    = 3'd0;
    localparam logic [2:0] CFG_MASK_B    = 3'd1;
    localparam logic [2:0] CFG_MASK_C    = 3'd2;
    localparam logic [2:0] CFG_MASK_D    = 3'd3;
    localparam logic [2:0] CFG_RIGHT     = 3'd4;
    localparam logic [2:0] CFG_MIN_GREEN = 3'd5;
    localparam logic [2:0] CFG_AMBER     = 3'd6;
    localparam logic [2:0] CFG_ALL_RED   = 3'd7;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;
endpackage
`default_nettype wire

>>> sv/wgs_div.sv
// shared unsigned restoring divider, one quotient bit per cycle
// depends on wgs_pkg
`default_nettype none
module wgs_div
    import wgs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire div_req_t             req,
    output logic                      done,
    output logic [DIV_NUM_W-1:0]      quot
);
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   trial;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_NUM_W-1]};
        trial     = shifted - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next = req.num;
            rem_next = '0;
            den_next = req.den;
            cnt_next = 6'(DIV_NUM_W);
        end
        else if (cnt_reg != 6'd0)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = trial[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
endmodule
`default_nettype wire

>>> sv/webster_green_split_unit.sv
// top level of the webster green split unit: link store, sequencer, outputs
// depends on wgs_pkg and wgs_div
`default_nettype none
// demands load one per cycle while busy is low; a request with last_link set
// starts the split computation and busy rises. the sequencer walks the 24
// links: S_RATIO alone for a link green in no phase or a permissive right
// turn, S_RATIO then S_RWAIT for an eligible one (ratio by reciprocal
// multiply, then the phase maxima), then S_LOSS, S_LWAIT and S_CLASS for the
// total, the clearance loss and the classification. a computed split then
// divides for the cycle length on the shared 36-bit divider and, per phase,
// multiplies and divides, skipping the divide for a negative product. a
// zero, negative or overloaded total goes straight to the results. busy
// stays high until the last result is out; results come one per phase, each
// marked by strobe for a single cycle; the receiver cannot stall them, so it
// must take every strobe. the link store is emptied at the end of each
// computation through its valid bits, with no clearing pass. configuration
// writes are always ready and must only be made while idle.
module webster_green_split_unit
    import wgs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [LINK_W-1:0]     link_index,
    input  wire logic [DEMAND_W-1:0]   link_demand,
    input  wire logic                  last_link,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [MASK_W-1:0]     cfg_data,
    output logic                       strobe,
    output logic [1:0]                 phase_number,
    output logic [TIME_W-1:0]          green_time,
    output logic [1:0]                 split_status,
    output logic                       last_phase
);
    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RATIO = 4'd1;
    localparam logic [3:0] S_RWAIT = 4'd2;
    localparam logic [3:0] S_LOSS  = 4'd3;
    localparam logic [3:0] S_LWAIT = 4'd4;
    localparam logic [3:0] S_CLASS = 4'd5;
    localparam logic [3:0] S_CYC   = 4'd6;
    localparam logic [3:0] S_CWAIT = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_SPLIT = 4'd9;
    localparam logic [3:0] S_SWAIT = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    // configuration registers
    logic [MASK_W-1:0] mask_reg [NUM_PHASES];
    logic [MASK_W-1:0] right_reg;
    logic [TIME_W-1:0] min_green_reg;
    logic [TIME_W-1:0] amber_reg;
    logic [TIME_W-1:0] all_red_reg;

    // link store, valid bits give the cleared value
    logic [DEMAND_W-1:0]  store_reg [NUM_LINKS];
    logic [NUM_LINKS-1:0] valid_reg;

    logic [3:0]                state_reg, state_next;
    logic [LINK_W-1:0]         link_reg, link_next;
    logic [1:0]                phase_reg, phase_next;
    logic signed [RATIO_W-1:0] best_reg [NUM_PHASES];
    logic signed [RATIO_W-1:0] best_next [NUM_PHASES];
    logic signed [TOTAL_W-1:0] y_reg, y_next;
    logic [2:0]                active_reg, active_next;
    logic [16:0]               loss_reg, loss_next;
    logic [16:0]               ratio_reg, ratio_next;
    logic signed [17:0]        eff_reg, eff_next;
    logic signed [35:0]        prod_reg, prod_next;
    logic [TIME_W-1:0]         green_reg [NUM_PHASES];
    logic [TIME_W-1:0]         green_next [NUM_PHASES];
    logic [1:0]                mode_reg, mode_next;
    logic                      bad_reg, bad_next;

    div_req_t             div_req;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;

    logic [MASK_W-1:0]     elig [NUM_PHASES];
    logic [MASK_W-1:0]     any_elig;
    logic [DEMAND_W-1:0]   cur_demand;
    logic [23:0]           ratio_num;
    logic [48:0]           ratio_prod;
    logic [16:0]           link_ratio;
    logic [17:0]           chg_sum;
    logic [36:0]           chg_prod;
    logic                  in_req;
    logic                  last_phase_w;
    logic signed [TOTAL_W-1:0] y_sum;
    logic [2:0]            active_sum;
    logic [16:0]           y_room;
    logic [18:0]           num2;
    logic [14:0]           cycle_len;

    wgs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign in_req    = start && !busy;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PHASES; p++)
            begin
                mask_reg[p] <= '0;
            end
            right_reg     <= '0;
            min_green_reg <= 16'd1280;
            amber_reg     <= 16'd768;
            all_red_reg   <= 16'd512;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MASK_A:    mask_reg[0]   <= cfg_data;
                CFG_MASK_B:    mask_reg[1]   <= cfg_data;
                CFG_MASK_C:    mask_reg[2]   <= cfg_data;
                CFG_MASK_D:    mask_reg[3]   <= cfg_data;
                CFG_RIGHT:     right_reg     <= cfg_data;
                CFG_MIN_GREEN: min_green_reg <= cfg_data[TIME_W-1:0];
                CFG_AMBER:     amber_reg     <= cfg_data[TIME_W-1:0];
                CFG_ALL_RED:   all_red_reg   <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // store write on an accepted request, index beyond the links is dropped
    always_ff @(posedge clk)
    begin
        if (in_req && (link_index < LINK_W'(NUM_LINKS)))
        begin
            store_reg[link_index] <= link_demand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (state_reg == S_OUT && phase_reg == 2'(NUM_PHASES - 1))
        begin
            // computation finished: store reads as empty again
            valid_reg <= '0;
        end
        else if (in_req && (link_index < LINK_W'(NUM_LINKS)))
        begin
            valid_reg[link_index] <= 1'b1;
        end
    end

    // links green in a phase and not a permissive right turn
    always_comb
    begin
        any_elig = '0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            elig[p]  = mask_reg[p] & ~right_reg;
            any_elig = any_elig | elig[p];
        end
    end

    assign cur_demand = valid_reg[link_reg] ? store_reg[link_reg] : '0;

    // round(demand * 65536 / 2400) by reciprocal multiply, exact below saturation
    assign ratio_num  = {cur_demand[12:0], 11'd0} + RATIO_BIAS;
    assign ratio_prod = ratio_num * RECIP_75;
    assign link_ratio = (cur_demand >= RATIO_SAT_DEM) ? RATIO_MAX : ratio_prod[47:31];

    // round(0.2 * change) as (change + 2) / 5, reciprocal multiply
    assign chg_sum  = 18'(amber_reg) + 18'(all_red_reg) + 18'd2;
    assign chg_prod = chg_sum * RECIP_5;

    // total ratio and count of phases with a nonzero ratio
    always_comb
    begin
        y_sum      = '0;
        active_sum = '0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            y_sum = y_sum + TOTAL_W'(best_reg[p]);
            if (best_reg[p] != '0)
            begin
                active_sum = active_sum + 3'd1;
            end
        end
    end

    assign y_room    = Q_ONE - y_reg[16:0];
    assign num2      = 19'(3 * loss_reg) + 19'(FIXED_OVH2);
    assign cycle_len = (div_quot > DIV_NUM_W'(CYCLE_MAX)) ? CYCLE_MAX : div_quot[14:0];
    assign last_phase_w = (phase_reg == 2'(NUM_PHASES - 1));

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        link_next   = link_reg;
        phase_next  = phase_reg;
        y_next      = y_reg;
        active_next = active_reg;
        loss_next   = loss_reg;
        ratio_next  = ratio_reg;
        eff_next    = eff_reg;
        prod_next   = prod_reg;
        mode_next   = mode_reg;
        bad_next    = bad_reg;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            best_next[p]  = best_reg[p];
            green_next[p] = green_reg[p];
        end
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_req && last_link)
                begin
                    link_next = '0;
                    bad_next  = 1'b0;
                    for (int p = 0; p < NUM_PHASES; p++)
                    begin
                        best_next[p] = RATIO_NONE;
                    end
                    state_next = S_RATIO;
                end
            end
            S_RATIO:
            begin
                if (any_elig[link_reg])
                begin
                    ratio_next = link_ratio;
                    state_next = S_RWAIT;
                end
                else if (link_reg == LINK_W'(NUM_LINKS - 1))
                begin
                    state_next = S_LOSS;
                end
                else
                begin
                    link_next = link_reg + LINK_W'(1);
                end
            end
            S_RWAIT:
            begin
                for (int p = 0; p < NUM_PHASES; p++)
                begin
                    if (elig[p][link_reg] && ($signed({1'b0, ratio_reg}) > best_reg[p]))
                    begin
                        best_next[p] = $signed({1'b0, ratio_reg});
                    end
                end
                if (link_reg == LINK_W'(NUM_LINKS - 1))
                begin
                    state_next = S_LOSS;
                end
                else
                begin
                    link_next  = link_reg + LINK_W'(1);
                    state_next = S_RATIO;
                end
            end
            S_LOSS:
            begin
                y_next      = y_sum;
                active_next = active_sum;
                // per-phase loss: 1 s start-up plus the clearance share
                loss_next   = 17'(STARTUP_LOSS) + {1'b0, chg_prod[36:21]};
                state_next  = S_LWAIT;
            end
            S_LWAIT:
            begin
                loss_next  = 17'(loss_reg * 17'(active_reg));
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                phase_next = '0;
                if (y_reg < 0)
                begin
                    mode_next  = ST_INVALID;
                    state_next = S_OUT;
                end
                else if (y_reg == '0)
                begin
                    mode_next  = ST_ZERO;
                    state_next = S_OUT;
                end
                else if (y_reg >= $signed(TOTAL_W'(Q_ONE)))
                begin
                    mode_next  = ST_OVERLOAD;
                    state_next = S_OUT;
                end
                else
                begin
                    mode_next  = ST_COMPUTED;
                    state_next = S_CYC;
                end
            end
            S_CYC:
            begin
                // cycle = round(num2 * 65536 / (2 * (1 - y)))
                div_req.start = 1'b1;
                div_req.num   = {1'b0, num2, 16'd0} + DIV_NUM_W'(y_room);
                div_req.den   = {y_room, 1'b0};
                state_next    = S_CWAIT;
            end
            S_CWAIT:
            begin
                if (div_done)
                begin
                    eff_next   = $signed({3'd0, cycle_len}) - $signed({1'b0, loss_reg});
                    phase_next = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = best_reg[phase_reg] * eff_reg;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                if (prod_reg < 0)
                begin
                    bad_next = 1'b1;
                    if (last_phase_w)
                    begin
                        mode_next  = ST_INVALID;
                        phase_next = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    // round half away from zero of prod / y
                    div_req.start = 1'b1;
                    div_req.num   = prod_reg[DIV_NUM_W-1:0] + DIV_NUM_W'(y_reg[16:1]);
                    div_req.den   = DIV_DEN_W'(y_reg[16:0]);
                    state_next    = S_SWAIT;
                end
            end
            S_SWAIT:
            begin
                if (div_done)
                begin
                    if (div_quot == '0)
                    begin
                        green_next[phase_reg] = min_green_reg;
                    end
                    else if (div_quot > DIV_NUM_W'(16'hFFFF))
                    begin
                        green_next[phase_reg] = 16'hFFFF;
                    end
                    else
                    begin
                        green_next[phase_reg] = div_quot[TIME_W-1:0];
                    end
                    if (last_phase_w)
                    begin
                        if (bad_reg)
                        begin
                            mode_next = ST_INVALID;
                        end
                        phase_next = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_OUT:
            begin
                if (last_phase_w)
                begin
                    phase_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            link_reg  <= '0;
            phase_reg <= '0;
            mode_reg  <= ST_COMPUTED;
            bad_reg   <= 1'b0;
            for (int p = 0; p < NUM_PHASES; p++)
            begin
                best_reg[p] <= '0;
            end
            y_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            link_reg  <= link_next;
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            bad_reg   <= bad_next;
            for (int p = 0; p < NUM_PHASES; p++)
            begin
                best_reg[p] <= best_next[p];
            end
            y_reg     <= y_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        active_reg <= active_next;
        loss_reg   <= loss_next;
        ratio_reg  <= ratio_next;
        eff_reg    <= eff_next;
        prod_reg   <= prod_next;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            green_reg[p] <= green_next[p];
        end
    end

    // result ports, one phase per cycle during the output burst
    assign busy         = (state_reg != S_IDLE);
    assign strobe       = (state_reg == S_OUT);
    assign phase_number = phase_reg;
    assign last_phase   = strobe && last_phase_w;
    assign split_status = mode_reg;
    always_comb
    begin
        case (mode_reg)
            ST_COMPUTED: green_time = green_reg[phase_reg];
            ST_ZERO:     green_time = min_green_reg;
            default:     green_time = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> sv/wgs_checker.sv
// port-level checker of the webster green split unit, bound to the top level
// depends on wgs_pkg and webster_green_split_unit_defines.svh
`default_nettype none
`include "webster_green_split_unit_defines.svh"
module wgs_checker
    import wgs_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 last_link,
    input wire logic                 strobe,
    input wire logic [1:0]           phase_number,
    input wire logic [TIME_W-1:0]    green_time,
    input wire logic [1:0]           split_status,
    input wire logic                 last_phase
);
    // results only come while the block is busy
    `WGS_ASSERT_NOW(a_strobe_busy, clk, rst_n, strobe, busy)
    // a burst of results runs on without gaps, phase by phase
    `WGS_ASSERT_NEXT(a_burst_cont, clk, rst_n, strobe && !last_phase,
        strobe && (phase_number == $past(phase_number) + 2'd1))
    // the burst ends after the last phase
    `WGS_ASSERT_NEXT(a_burst_end, clk, rst_n, strobe && last_phase, !strobe)
    // overloaded or invalid results carry no green
    `WGS_ASSERT_NOW(a_err_zero, clk, rst_n,
        strobe && (split_status == ST_OVERLOAD || split_status == ST_INVALID),
        green_time == '0)
    // a last link request starts a computation
    `WGS_ASSERT_NEXT(a_last_busy, clk, rst_n, start && !busy && last_link, busy)
endmodule

bind webster_green_split_unit wgs_checker u_wgs_checker (.*);
`default_nettype wire

>>> tb/sv/webster_green_split_unit_checker.sv
// checker for the webster green split unit: predicts the four phase splits
// depends on wgs_pkg; watches the request, configuration and result ports
`timescale 1ns / 1ps
module webster_green_split_unit_checker
    import wgs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire logic [LINK_W-1:0]     link_index,
    input  wire logic [DEMAND_W-1:0]   link_demand,
    input  wire logic                  last_link,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [MASK_W-1:0]     cfg_data,
    input  wire logic                  strobe,
    input  wire logic [1:0]            phase_number,
    input  wire logic [TIME_W-1:0]     green_time,
    input  wire logic [1:0]            split_status,
    input  wire logic                  last_phase,
    output int                         fail_count,
    output int                         splits_pending
);
    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] green;
        logic [1:0]  status;
        logic        last;
    } split_t;

    split_t      split_queue[$];
    logic [23:0] green_mask[NUM_PHASES];
    logic [23:0] right_mask;
    logic [15:0] min_green_q, amber_q, all_red_q;
    logic [15:0] demand_mem[NUM_LINKS];

    assign splits_pending = split_queue.size();

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        begin
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        end
    endfunction

    task automatic predict_splits();
        longint ratio[NUM_PHASES];
        longint best, r, y, active, loss, num2, den, cycle, eff, prod, g;
        logic [15:0] gr[NUM_PHASES];
        logic [1:0]  st[NUM_PHASES];
        bit bad;
        split_t s;
        begin
            y = 0;
            active = 0;
            bad = 0;
            for (int p = 0; p < NUM_PHASES; p++)
            begin
                best = -65536;
                for (int i = 0; i < NUM_LINKS; i++)
                    if (green_mask[p][i] && !right_mask[i])
                    begin
                        r = (longint'(demand_mem[i]) * 65536 + 1200) / 2400;
                        if (r > 131071) r = 131071;
                        if (r > best) best = r;
                    end
                ratio[p] = best;
                y += best;
                if (best != 0) active++;
            end
            if (y > 524287) y = 524287;
            if (y < -524288) y = -524288;
            for (int p = 0; p < NUM_PHASES; p++)
            begin
                if (y < 0) begin st[p] = ST_INVALID; gr[p] = '0; end
                else if (y == 0) begin st[p] = ST_ZERO; gr[p] = min_green_q; end
                else if (y >= 65536) begin st[p] = ST_OVERLOAD; gr[p] = '0; end
                else begin st[p] = ST_COMPUTED; gr[p] = '0; end
            end
            if (y > 0 && y < 65536)
            begin
                loss = (256 + (longint'(amber_q) + longint'(all_red_q) + 2) / 5) * active;
                num2 = 3 * loss + 2 * 1280;
                den = 2 * (65536 - y);
                cycle = (num2 * 65536 + den / 2) / den;
                if (cycle > 30720) cycle = 30720;
                eff = cycle - loss;
                for (int p = 0; p < NUM_PHASES; p++)
                begin
                    prod = ratio[p] * eff;
                    if (prod < 0)
                        bad = 1;
                    else
                    begin
                        g = round_div(prod, y);
                        if (g == 0) g = min_green_q;
                        if (g > 65535) g = 65535;
                        gr[p] = g[15:0];
                    end
                end
                if (bad)
                    for (int p = 0; p < NUM_PHASES; p++)
                    begin
                        st[p] = ST_INVALID;
                        gr[p] = '0;
                    end
            end
            for (int i = 0; i < NUM_LINKS; i++) demand_mem[i] = '0;
            for (int p = 0; p < NUM_PHASES; p++)
            begin
                s.phase = p[1:0];
                s.green = gr[p];
                s.status = st[p];
                s.last = (p == NUM_PHASES - 1);
                split_queue.push_back(s);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        split_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            split_queue.delete();
            for (int p = 0; p < NUM_PHASES; p++) green_mask[p] = '0;
            right_mask = '0;
            min_green_q = 16'd1280;
            amber_q = 16'd768;
            all_red_q = 16'd512;
            for (int i = 0; i < NUM_LINKS; i++) demand_mem[i] = '0;
        end
        else
        begin
            if (strobe)
            begin
                if (split_queue.size() == 0)
                begin
                    $display("%0t unexpected split: phase %0d green %0d status %0d",
                             $time, phase_number, green_time, split_status);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = split_queue.pop_front();
                    if (want != {phase_number, green_time, split_status, last_phase})
                    begin
                        $display("%0t split mismatch: expected %h actual %h", $time,
                                 want, {phase_number, green_time, split_status, last_phase});
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_MASK_A, CFG_MASK_B, CFG_MASK_C, CFG_MASK_D:
                        green_mask[cfg_index[1:0]] = cfg_data;
                    CFG_RIGHT:     right_mask = cfg_data;
                    CFG_MIN_GREEN: min_green_q = cfg_data[15:0];
                    CFG_AMBER:     amber_q = cfg_data[15:0];
                    default:       all_red_q = cfg_data[15:0];
                endcase
            if (start && !busy)
            begin
                if (link_index < NUM_LINKS) demand_mem[link_index] = link_demand;
                if (last_link) predict_splits();
            end
        end
    end
endmodule

>>> tb/sv/webster_green_split_unit_tb.sv
// stimulus and verdict for the webster green split unit
// depends on wgs_pkg, webster_green_split_unit and its checker
`timescale 1ns / 1ps
module webster_green_split_unit_tb;
    import wgs_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 start = 0;
    logic                 busy;
    logic [LINK_W-1:0]    link_index = 0;
    logic [DEMAND_W-1:0]  link_demand = 0;
    logic                 last_link = 0;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = 0;
    logic [MASK_W-1:0]    cfg_data = 0;
    logic                 strobe;
    logic [1:0]           phase_number;
    logic [TIME_W-1:0]    green_time;
    logic [1:0]           split_status;
    logic                 last_phase;
    int                   fail_count;
    int                   splits_pending;
    int                   cycle_count = 0;
    bit                   no_gaps = 0;

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    webster_green_split_unit u_top (.*);
    webster_green_split_unit_checker u_checker (.*);

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[webster_green_split_unit] ERROR");
            $finish;
        end
    end

    // random idle cycles before a request, unless in the gap-free stretch
    task automatic idle_gap();
        begin
            while (!no_gaps && $urandom_range(99) < 29)
            begin
                start <= 0;
                cfg_valid <= 0;
                @(posedge clk);
            end
        end
    endtask

    // one demand request; held until the block takes it
    task automatic send_link(logic [4:0] idx, logic [15:0] dem, logic last);
        begin
            idle_gap();
            start <= 1;
            cfg_valid <= 0;
            link_index <= idx;
            link_demand <= dem;
            last_link <= last;
            @(posedge clk);
            while (busy) @(posedge clk);
        end
    endtask

    // configuration write, only while idle
    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        begin
            idle_gap();
            cfg_valid <= 1;
            start <= 0;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
    endtask

    // wait until all splits are out, then let the sequencer settle
    task automatic drain();
        begin
            start <= 0;
            cfg_valid <= 0;
            @(posedge clk);
            while (busy || splits_pending != 0) @(posedge clk);
            repeat (50) @(posedge clk);
        end
    endtask

    // a random demand with the extremes well represented
    function automatic logic [15:0] pick_demand();
        int k;
        begin
            k = $urandom_range(9);
            if (k == 0) return 16'd0;
            if (k == 1) return 16'hFFFF;
            if (k < 6) return 16'($urandom_range(700));
            return 16'($urandom);
        end
    endfunction

    task automatic random_setting(int kind);
        begin
            for (int p = 0; p < 4; p++)
                write_reg(CFG_MASK_A + 3'(p), (kind == 0) ? 24'hFFFFFF :
                          ($urandom_range(3) == 0 ? 24'h0 : 24'($urandom)));
            write_reg(CFG_RIGHT, (kind == 0) ? 24'h0 : 24'($urandom & $urandom));
            write_reg(CFG_MIN_GREEN, 24'((kind == 0) ? 1 : (kind == 1) ? 65535
                                         : $urandom_range(1, 65535)));
            write_reg(CFG_AMBER, 24'((kind == 0) ? 65535 : (kind == 1) ? 1
                                     : $urandom_range(1, 2000)));
            write_reg(CFG_ALL_RED, 24'((kind == 0) ? 65535 : (kind == 1) ? 1
                                       : $urandom_range(1, 2000)));
        end
    endtask

    initial
    begin
        int sent;
        int n;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset masks: every phase empty so total is negative
        send_link(5'd0, 16'd100, 1'b1);
        drain();

        // one link per phase, right turns excluded, zero total
        write_reg(CFG_MASK_A, 24'h000001);
        write_reg(CFG_MASK_B, 24'h000002);
        write_reg(CFG_MASK_C, 24'h000004);
        write_reg(CFG_MASK_D, 24'h800008);
        write_reg(CFG_RIGHT, 24'h800000);
        send_link(5'd0, 16'd0, 1'b1);
        drain();
        // computed split with a tiny ratio giving a small green
        send_link(5'd0, 16'd400, 1'b0);
        send_link(5'd1, 16'd300, 1'b0);
        send_link(5'd2, 16'd1, 1'b0);
        send_link(5'd3, 16'd200, 1'b0);
        send_link(5'd23, 16'hFFFF, 1'b0);
        send_link(5'd31, 16'hFFFF, 1'b1);   // index out of range
        drain();
        // overload with saturated ratios
        send_link(5'd0, 16'hFFFF, 1'b0);
        send_link(5'd1, 16'hFFFF, 1'b0);
        send_link(5'd2, 16'hFFFF, 1'b0);
        send_link(5'd3, 16'hFFFF, 1'b1);
        drain();
        // one empty phase with others nonzero gives a negative total
        write_reg(CFG_MASK_D, 24'h0);
        send_link(5'd0, 16'd1000, 1'b0);
        send_link(5'd1, 16'd24, 1'b0);
        send_link(5'd2, 16'd1300, 1'b1);
        drain();
        random_setting(0);
        send_link(5'd5, 16'd600, 1'b1);
        drain();
        random_setting(1);
        send_link(5'd7, 16'd500, 1'b1);
        drain();

        sent = 0;
        while (sent < 280)
        begin
            if ($urandom_range(3) == 0) random_setting(2);
            no_gaps = (sent > 120 && sent < 170);
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_link(5'(($urandom_range(9) == 0) ? $urandom_range(24, 31)
                                                      : $urandom_range(23)),
                          pick_demand(), i == n - 1);
            sent += n;
            drain();
        end

        if (fail_count == 0)
            $display("[webster_green_split_unit] OK");
        else
            $display("[webster_green_split_unit] ERROR");
        $finish;
    end
endmodule
